@@ rtl/timer_counter_compare_slopes_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the timer/counter block
// Short forms for same-cycle and next-cycle implications under reset.
// ----------------------------------------------------------------------------
`ifndef TIMER_COUNTER_COMPARE_SLOPES_ASSERT_SVH
`define TIMER_COUNTER_COMPARE_SLOPES_ASSERT_SVH

// same-cycle implication
`define TCS_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tcs_pkg
// Types and constants shared by the timer/counter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcs_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int NUM_COMPARE_DEF = 3;
  localparam int FIELD_W         = 16;
  localparam int NUM_CMP_MAX     = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int SLOPE_W         = 2;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  typedef enum logic [SLOPE_W-1:0] {
    SLOPE_INC  = 2'd0,
    SLOPE_DEC  = 2'd1,
    SLOPE_DUAL = 2'd2,
    SLOPE_FREE = 2'd3   // steps in current direction, no reversal
  } slope_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_SLOPE  = 3'd1,
    REG_TOP    = 3'd2,
    REG_CMP_EN = 3'd3,
    REG_CMP_A  = 3'd4,
    REG_CMP_B  = 3'd5,
    REG_CMP_C  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                   count_enable;
    slope_t                 slope_mode;
    logic [FIELD_W-1:0]     top_value;
    logic [NUM_CMP_MAX-1:0] cmp_enable;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0]     count_now;
    logic                   hit_max;
    logic                   hit_top;
    logic                   hit_bottom;
    logic [NUM_CMP_MAX-1:0] match_mask;
    logic                   going_down;
  } res_t;

endpackage

@@ rtl/timer_counter_compare_slopes.sv @@
// ----------------------------------------------------------------------------
// timer_counter_compare_slopes
// 16-bit style timer/counter with TOP, up/down/dual-slope and compare flags.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): opcode selects a counting tick or a load
// of load_value. Each accepted word yields exactly one result word on the
// output channel (out_valid/out_stall): the count after the item, the
// MAX/TOP/BOTTOM flags and compare matches seen before the tick, and the
// direction. Results are registered (result or skid register); throughput is
// one word per cycle while in_stall is low, since the next count is formed in
// a single pass from the count register and written with the result register.
// A two-entry output buffer (result register plus skid register) lets a word
// be taken while the previous result waits; in_stall rises only when both
// entries are full, and is driven from a register.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// the user must make writes while the block is idle; the block does not
// enforce this. Writing slope_mode 0 or 1 also sets the direction to up or down.
// Reset (rst, synchronous) clears the count, direction, registers (top_value
// to all ones) and empties the output buffer. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timer_counter_compare_slopes_assert.svh"

module timer_counter_compare_slopes #(
  parameter int COUNT_BITS  = tcs_pkg::COUNT_BITS_DEF,
  parameter int NUM_COMPARE = tcs_pkg::NUM_COMPARE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcs_pkg::FIELD_W-1:0]         cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [tcs_pkg::FIELD_W-1:0]         load_value,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tcs_pkg::FIELD_W-1:0]         count_now,
  output logic                                hit_max,
  output logic                                hit_top,
  output logic                                hit_bottom,
  output logic [tcs_pkg::NUM_CMP_MAX-1:0]     match_mask,
  output logic                                going_down
);
  import tcs_pkg::*;

  cfg_t                                  cfg;
  logic [NUM_COMPARE-1:0][FIELD_W-1:0]   cmp_val;
  logic [COUNT_BITS-1:0]                 count;
  logic                                  down_dir;
  logic [COUNT_BITS-1:0]                 count_next;
  logic                                  down_dir_next;
  res_t                                  res_next;
  res_t                                  res_q;
  res_t                                  skid_q;
  logic                                  skid_valid;
  logic                                  cfg_wr;
  logic                                  in_acc;
  logic                                  out_pop;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = skid_valid;
  assign in_acc    = in_valid && !in_stall;
  assign out_pop   = out_valid && !out_stall;

  tcs_step #(
    .COUNT_BITS  (COUNT_BITS),
    .NUM_COMPARE (NUM_COMPARE)
  ) u_step (
    .cnt        (count),
    .dir        (down_dir),
    .is_load    (opcode == OP_LOAD),
    .load_value (load_value),
    .cfg        (cfg),
    .cmp_val    (cmp_val),
    .cnt_next   (count_next),
    .dir_next   (down_dir_next),
    .res        (res_next)
  );

  // configuration registers and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_enable <= 1'b0;
      cfg.slope_mode   <= SLOPE_INC;
      cfg.top_value    <= '1;
      cfg.cmp_enable   <= '0;
      count            <= '0;
      down_dir         <= 1'b0;
    end else begin
      if (in_acc) begin
        count    <= count_next;
        down_dir <= down_dir_next;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_ENABLE: cfg.count_enable <= cfg_data[0];
          REG_SLOPE: begin
            cfg.slope_mode <= slope_t'(cfg_data[SLOPE_W-1:0]);
            if (slope_t'(cfg_data[SLOPE_W-1:0]) == SLOPE_INC) begin
              down_dir <= 1'b0;
            end else if (slope_t'(cfg_data[SLOPE_W-1:0]) == SLOPE_DEC) begin
              down_dir <= 1'b1;
            end
          end
          REG_TOP:    cfg.top_value  <= cfg_data;
          REG_CMP_EN: cfg.cmp_enable <= cfg_data[NUM_CMP_MAX-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // compare values sit at consecutive indexes from REG_CMP_A
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_val <= '0;
    end else if (cfg_wr) begin
      for (int i = 0; i < NUM_COMPARE; i++) begin
        if (cfg_index == CFG_IDX_W'(int'(REG_CMP_A) + i)) begin
          cmp_val[i] <= cfg_data;
        end
      end
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        res_q      <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid || out_pop) begin
        res_q     <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_q     <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  assign count_now  = res_q.count_now;
  assign hit_max    = res_q.hit_max;
  assign hit_top    = res_q.hit_top;
  assign hit_bottom = res_q.hit_bottom;
  assign match_mask = res_q.match_mask;
  assign going_down = res_q.going_down;

  `TCS_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid,
    "skid entry full while result register empty")

  `TCS_ASSERT_NEXT(a_load_no_flags, clk, rst,
    in_acc && opcode == OP_LOAD && !out_valid,
    out_valid && !hit_max && !hit_top && !hit_bottom && match_mask == '0,
    "load word produced flags")

  `TCS_ASSERT_NEXT(a_disabled_hold, clk, rst,
    in_acc && opcode == OP_TICK && !cfg.count_enable,
    count == $past(count),
    "count moved while disabled")

  `TCS_ASSERT_SAME(a_up_mode_dir, clk, rst, cfg.slope_mode == SLOPE_INC, !down_dir,
    "counting down in up mode")

endmodule

@@ rtl/tcs_step.sv @@
// ----------------------------------------------------------------------------
// tcs_step
// Next-count and flag logic for one item: flags on the current count, then
// step, wrap, reverse or reload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcs_step #(
  parameter int COUNT_BITS  = tcs_pkg::COUNT_BITS_DEF,
  parameter int NUM_COMPARE = tcs_pkg::NUM_COMPARE_DEF
) (
  input  logic [COUNT_BITS-1:0]                          cnt,
  input  logic                                           dir,
  input  logic                                           is_load,
  input  logic [tcs_pkg::FIELD_W-1:0]                    load_value,
  input  tcs_pkg::cfg_t                                  cfg,
  input  logic [NUM_COMPARE-1:0][tcs_pkg::FIELD_W-1:0]   cmp_val,
  output logic [COUNT_BITS-1:0]                          cnt_next,
  output logic                                           dir_next,
  output tcs_pkg::res_t                                  res
);
  import tcs_pkg::*;

  // common width for comparing count against 16-bit register values
  localparam int CMP_W = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

  logic [CMP_W-1:0]       cnt_w;
  logic [CMP_W-1:0]       top_w;
  logic [CMP_W-1:0]       top_m1_w;
  logic [CMP_W-1:0]       next_w;
  logic [NUM_CMP_MAX-1:0] hits;

  assign cnt_w    = CMP_W'(cnt);
  assign top_w    = CMP_W'(cfg.top_value);
  assign top_m1_w = top_w - CMP_W'(1);

  genvar gi;
  generate
    for (gi = 0; gi < NUM_CMP_MAX; gi++) begin : g_cmp
      if (gi < NUM_COMPARE) begin : g_on
        assign hits[gi] = cfg.cmp_enable[gi] && (cnt_w == CMP_W'(cmp_val[gi]));
      end else begin : g_off
        assign hits[gi] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    logic f_max;
    logic f_top;
    logic f_bot;
    logic top_zero;
    logic tick;

    tick     = !is_load && cfg.count_enable;
    f_max    = &cnt;
    f_top    = (cnt_w == top_w);
    f_bot    = (cnt == '0);
    top_zero = (cfg.top_value == '0);

    cnt_next = cnt;
    dir_next = dir;

    if (is_load) begin
      cnt_next = COUNT_BITS'(CMP_W'(load_value));
    end else if (cfg.count_enable) begin
      cnt_next = dir ? (cnt - COUNT_BITS'(1)) : (cnt + COUNT_BITS'(1));
      if (f_max && !f_top) begin
        cnt_next = '0;
      end
      if (f_top) begin
        if (cfg.slope_mode == SLOPE_INC || top_zero) begin
          cnt_next = '0;
        end else if (cfg.slope_mode == SLOPE_DUAL && !dir) begin
          dir_next = 1'b1;
          cnt_next = top_m1_w[COUNT_BITS-1:0];
        end
      end
      // reversal at bottom looks at the direction after the TOP action
      if (f_bot && !top_zero) begin
        if (cfg.slope_mode == SLOPE_DEC) begin
          cnt_next = top_w[COUNT_BITS-1:0];
        end else if (cfg.slope_mode == SLOPE_DUAL && dir_next) begin
          dir_next = 1'b0;
          cnt_next = COUNT_BITS'(1);
        end
      end
    end

    next_w         = CMP_W'(cnt_next);
    res.count_now  = next_w[FIELD_W-1:0];
    res.hit_max    = tick && f_max;
    res.hit_top    = tick && f_top;
    res.hit_bottom = tick && f_bot;
    res.match_mask = tick ? hits : '0;
    res.going_down = dir_next;
  end

endmodule

@@ verif/timer_counter_compare_slopes_tb.sv @@
// ----------------------------------------------------------------------------
// timer_counter_compare_slopes_tb
// Self-checking bench for the timer/counter with TOP, slopes and compares.
// A short directed run covers each slope mode, the TOP, MAX and BOTTOM
// actions, loads and disabled ticks. Random phases follow, each one with its
// own register settings. A scoreboard class tracks the count and direction,
// predicts every result word and checks it against the block's output, while
// both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_counter_compare_slopes_tb;
  import tcs_pkg::*;

  class count_tracker;
    logic [15:0] cnt;
    bit          down;
    bit          enable;
    slope_t      slope;
    logic [15:0] top;
    logic [2:0]  cmp_en;
    logic [15:0] cmp_val [3];
    res_t        due_words[$];
    int          errors;

    function new();
      cnt     = '0;
      down    = 1'b0;
      enable  = 1'b0;
      slope   = SLOPE_INC;
      top     = 16'hFFFF;
      cmp_en  = '0;
      cmp_val = '{16'd0, 16'd0, 16'd0};
      errors  = 0;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] data);
      case (idx)
        REG_ENABLE: enable = data[0];
        REG_SLOPE: begin
          slope = slope_t'(data[1:0]);
          if (slope == SLOPE_INC) down = 1'b0;
          else if (slope == SLOPE_DEC) down = 1'b1;
        end
        REG_TOP:    top        = data;
        REG_CMP_EN: cmp_en     = data[2:0];
        REG_CMP_A:  cmp_val[0] = data;
        REG_CMP_B:  cmp_val[1] = data;
        REG_CMP_C:  cmp_val[2] = data;
        default: ;
      endcase
    endfunction

    // one accepted input word: flags from the current count, then the step
    function void note_word(opcode_t op, logic [15:0] value);
      res_t        r;
      logic [15:0] nxt;
      r = '0;
      if (op == OP_LOAD) begin
        cnt = value;
      end else if (enable) begin
        r.hit_max    = (cnt == 16'hFFFF);
        r.hit_top    = (cnt == top);
        r.hit_bottom = (cnt == 16'd0);
        for (int i = 0; i < 3; i++)
          r.match_mask[i] = cmp_en[i] && (cnt == cmp_val[i]);
        nxt = down ? cnt - 16'd1 : cnt + 16'd1;
        if (r.hit_max && !r.hit_top) nxt = '0;
        if (r.hit_top) begin
          if (slope == SLOPE_INC || top == 16'd0) begin
            nxt = '0;
          end else if (slope == SLOPE_DUAL && !down) begin
            down = 1'b1;
            nxt  = top - 16'd1;
          end
        end
        if (r.hit_bottom && top != 16'd0) begin
          if (slope == SLOPE_DEC) begin
            nxt = top;
          end else if (slope == SLOPE_DUAL && down) begin
            down = 1'b0;
            nxt  = 16'd1;
          end
        end
        cnt = nxt;
      end
      r.count_now  = cnt;
      r.going_down = down;
      due_words = {due_words, r};
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (due_words.size() == 0) begin
        $display("%0t: result word with nothing expected, count_now %h", $time,
                 got.count_now);
        errors++;
        return;
      end
      want = due_words.pop_front();
      compare_field("count_now", want.count_now, got.count_now);
      compare_field("hit_max", 16'(want.hit_max), 16'(got.hit_max));
      compare_field("hit_top", 16'(want.hit_top), 16'(got.hit_top));
      compare_field("hit_bottom", 16'(want.hit_bottom), 16'(got.hit_bottom));
      compare_field("match_mask", 16'(want.match_mask), 16'(got.match_mask));
      compare_field("going_down", 16'(want.going_down), 16'(got.going_down));
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [FIELD_W-1:0]     cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   opcode;
  logic [FIELD_W-1:0]     load_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [FIELD_W-1:0]     count_now;
  logic                   hit_max;
  logic                   hit_top;
  logic                   hit_bottom;
  logic [NUM_CMP_MAX-1:0] match_mask;
  logic                   going_down;

  count_tracker tracker = new();
  bit           quiet;
  bit           calm;
  int           stall_left;

  timer_counter_compare_slopes u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .load_value (load_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .count_now  (count_now),
    .hit_max    (hit_max),
    .hit_top    (hit_top),
    .hit_bottom (hit_bottom),
    .match_mask (match_mask),
    .going_down (going_down)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || quiet || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        tracker.write_reg(reg_idx_t'(cfg_index), cfg_data);
      if (in_valid && !in_stall)
        tracker.note_word(opcode_t'(opcode), load_value);
      if (out_valid && !out_stall)
        tracker.check_word(res_t'({count_now, hit_max, hit_top, hit_bottom,
                                   match_mask, going_down}));
    end
  end

  // leaves in_valid high so back-to-back words need no second assignment
  task automatic send_word(opcode_t op, logic [15:0] value);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    load_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // narrow registers get random filler in the unused data bits
  task automatic program_timer(bit en, slope_t sl, logic [15:0] top_v, logic [2:0] ce,
                               logic [15:0] ca, logic [15:0] cb, logic [15:0] cc);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    drain();
    put_reg(REG_TOP, top_v);
    put_reg(REG_CMP_EN, {junk[15:3], ce});
    put_reg(REG_CMP_A, ca);
    put_reg(REG_CMP_B, cb);
    put_reg(REG_CMP_C, cc);
    put_reg(REG_ENABLE, {junk[15:1], en});
    put_reg(REG_SLOPE, {junk[15:2], sl});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_top();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      2:       v = 16'($urandom_range(0, 65535));
      default: v = 16'($urandom_range(1, 24));
    endcase
    return v;
  endfunction

  // values around the working range of the counter
  function automatic logic [15:0] pick_near(logic [15:0] top_v);
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'($urandom_range(0, 65535));
      1:       v = 16'd0;
      2:       v = 16'hFFFF;
      3:       v = 16'hFFFE;
      4:       v = top_v;
      5:       v = top_v - 16'd1;
      default: v = 16'($urandom_range(0, int'(top_v) + 2));
    endcase
    return v;
  endfunction

  initial begin
    int          random_words;
    int          len;
    logic [15:0] top_v;

    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_ENABLE;
    cfg_data   = '0;
    in_valid   = 1'b0;
    opcode     = OP_TICK;
    load_value = '0;
    out_stall  = 1'b0;
    quiet      = 1'b0;
    calm       = 1'b0;
    random_words = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // disabled after reset: ticks leave the count alone
    send_word(OP_TICK, 16'hFFFF);
    send_word(OP_LOAD, 16'hFFFF);
    send_word(OP_TICK, 16'h0000);
    in_valid <= 1'b0;

    // up: bottom, compares on 0, 2 and 3, wrap at TOP
    program_timer(1'b1, SLOPE_INC, 16'd3, 3'b111, 16'd0, 16'd2, 16'd3);
    send_word(OP_LOAD, 16'd0);
    repeat (4) send_word(OP_TICK, 16'd0);
    in_valid <= 1'b0;

    // down: reload TOP at bottom
    program_timer(1'b1, SLOPE_DEC, 16'd3, 3'b101, 16'd1, 16'd0, 16'hFFFF);
    send_word(OP_LOAD, 16'd1);
    repeat (3) send_word(OP_TICK, 16'd0);
    in_valid <= 1'b0;

    // dual slope: turn at TOP and at bottom
    program_timer(1'b1, SLOPE_DUAL, 16'd2, 3'b010, 16'd0, 16'd1, 16'd2);
    send_word(OP_LOAD, 16'd1);
    repeat (4) send_word(OP_TICK, 16'd0);
    in_valid <= 1'b0;

    // free-running mode with TOP 0: MAX wraps, TOP still clears
    program_timer(1'b1, SLOPE_FREE, 16'd0, 3'b001, 16'hFFFF, 16'd0, 16'd0);
    send_word(OP_LOAD, 16'hFFFF);
    repeat (2) send_word(OP_TICK, 16'd0);
    in_valid <= 1'b0;

    // MAX and TOP together
    program_timer(1'b1, SLOPE_INC, 16'hFFFF, 3'b000, 16'd0, 16'd0, 16'd0);
    send_word(OP_LOAD, 16'hFFFF);
    send_word(OP_TICK, 16'd0);
    in_valid <= 1'b0;

    while (random_words < 600) begin
      if (random_words > 500) quiet = 1'b1;
      calm  = ($urandom_range(0, 3) == 0);
      top_v = pick_top();
      program_timer($urandom_range(0, 7) != 0, slope_t'($urandom_range(0, 3)), top_v,
                    3'($urandom_range(0, 7)), pick_near(top_v), pick_near(top_v),
                    pick_near(top_v));
      len = $urandom_range(20, 60);
      send_word(OP_LOAD, pick_near(top_v));
      for (int n = 1; n < len; n++) begin
        if ($urandom_range(0, 9) == 0) send_word(OP_LOAD, pick_near(top_v));
        else send_word(OP_TICK, 16'($urandom_range(0, 65535)));
      end
      in_valid <= 1'b0;
      random_words += len;
    end

    drain();
    repeat (4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
